[design/rdes_pkg.sv]
// Package for the Roberts diagonal edge stream block.
// Holds the shared pixel width, register map codes and the result type.
// No dependencies.
package rdes_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam int LINE_WIDTH_RESET = 512;
    localparam int LINE_WIDTH_MIN   = 2;

    // Register word index, taken from paddr above the byte offset.
    localparam logic REG_LINE_WIDTH = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             end_of_row;
        logic             last;
    } t_result;

    // Which results the pixel held in the compute stage produces.
    typedef struct packed {
        logic res_main;
        logic res_end;
    } t_res_sel;

endpackage

[design/roberts_diagonal_edge_stream_top.sv]
// Roberts diagonal edge stream, top level. Uses rdes_pkg and rdes_line_store.
// Pixels arrive in raster order at one per clock; each result is the upper-left
// pixel minus the lower-right one, clamped at zero, emitted when the lower-right
// pixel arrives. The line store is a single-port memory that each accepted pixel
// reads and overwrites at its column in the same cycle, so a new pixel can be
// taken every clock. An accepted pixel is registered in the compute stage, then
// in the output queue. The last pixel of a row yields two results (its diagonal
// and the forced zero for the last column); it enters the two-entry output queue
// once the queue is empty or its only entry leaves in the same cycle, so with
// the output ready every clock the input is never held. Output stalls hold the
// input while the compute stage cannot push into the queue. The first row of
// each frame gives no results. The line store needs no clearing pass after reset.
module roberts_diagonal_edge_stream_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] frame_start
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] edge_res
    output logic                          m_tlast,   // end_of_row
    output logic                          m_tuser,   // [0] last
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdes_pkg::APB_AW-1:0]   paddr,
    input  logic [rdes_pkg::APB_DW-1:0]   pwdata,
    output logic [rdes_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EFF_RESET = (rdes_pkg::LINE_WIDTH_RESET > MAX_WIDTH) ?
                               MAX_WIDTH : rdes_pkg::LINE_WIDTH_RESET;

    // ---------------- Configuration ----------------
    logic [rdes_pkg::CFG_W-1:0] r_line_width, n_line_width;
    logic [WW-1:0]              r_eff_width, n_eff_width;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[rdes_pkg::APB_AW-1] == rdes_pkg::REG_LINE_WIDTH);

    always_comb begin
        int v;
        v            = int'(pwdata[rdes_pkg::CFG_W-1:0]);
        n_line_width = pwdata[rdes_pkg::CFG_W-1:0];
        if (v < rdes_pkg::LINE_WIDTH_MIN) begin
            v = rdes_pkg::LINE_WIDTH_MIN;
        end else if (v > MAX_WIDTH) begin
            v = MAX_WIDTH;
        end
        n_eff_width = WW'(v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= rdes_pkg::CFG_W'(rdes_pkg::LINE_WIDTH_RESET);
            r_eff_width  <= WW'(EFF_RESET);
        end else if (cfg_wr) begin
            r_line_width <= n_line_width;
            r_eff_width  <= n_eff_width;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[rdes_pkg::APB_AW-1] == rdes_pkg::REG_LINE_WIDTH) begin
            prdata = rdes_pkg::APB_DW'(r_line_width);
        end
    end

    // ---------------- Accept stage: column tracking ----------------
    logic                         accept;
    logic [CW-1:0]                col0;
    logic                         past0;
    logic [WW-1:0]                col_inc;
    logic [CW-1:0]                r_column, n_column;
    logic                         r_past, n_past;
    rdes_pkg::t_res_sel           sel0;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        if (s_tuser) begin
            col0  = '0;
            past0 = 1'b0;
        end else begin
            col0  = r_column;
            past0 = r_past;
        end
        // A width that shrank mid-row ends the current row.
        if (WW'(col0) >= r_eff_width) begin
            col0  = '0;
            past0 = 1'b1;
        end
        sel0.res_main = past0 && (col0 != '0);
        sel0.res_end  = past0 && (WW'(col0) == r_eff_width - WW'(1));
        col_inc = WW'(col0) + WW'(1);
        if (col_inc >= r_eff_width) begin
            n_column = '0;
            n_past   = 1'b1;
        end else begin
            n_column = CW'(col_inc);
            n_past   = past0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_past   <= 1'b0;
        end else if (accept) begin
            r_column <= n_column;
            r_past   <= n_past;
        end
    end

    logic [rdes_pkg::PIX_W-1:0] above;

    rdes_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (col0),
        .i_wdata (s_tdata[rdes_pkg::PIX_W-1:0]),
        .o_rdata (above)
    );

    // ---------------- Compute stage ----------------
    logic                         r_s1_valid;
    logic [rdes_pkg::PIX_W-1:0]   r_s1_pix;
    rdes_pkg::t_res_sel           r_s1_sel;
    logic [rdes_pkg::PIX_W-1:0]   r_held;

    logic                         r_q_valid [2];
    rdes_pkg::t_result            r_q       [2];
    logic                         n_q_valid [2];
    rdes_pkg::t_result            n_q       [2];

    logic                         push_ok;
    logic                         s1_go;
    logic                         pop;
    rdes_pkg::t_result            res_main;
    rdes_pkg::t_result            res_end;

    // Two results need a queue that is empty after this cycle's transfer,
    // one needs a tail slot that is free after it.
    always_comb begin
        if (r_s1_sel.res_main && r_s1_sel.res_end) begin
            push_ok = !r_q_valid[0] || (pop && !r_q_valid[1]);
        end else if (r_s1_sel.res_main || r_s1_sel.res_end) begin
            push_ok = !r_q_valid[1] || pop;
        end else begin
            push_ok = 1'b1;
        end
    end

    assign s1_go    = r_s1_valid && push_ok;
    assign s_tready = !r_s1_valid || push_ok;
    assign pop      = r_q_valid[0] && m_tready;

    always_comb begin
        res_main.edge_res   = (r_held > r_s1_pix) ? (r_held - r_s1_pix) : '0;
        res_main.end_of_row = 1'b0;
        res_main.last       = !r_s1_sel.res_end;
        res_end.edge_res    = '0;
        res_end.end_of_row  = 1'b1;
        res_end.last        = 1'b1;
    end

    always_comb begin
        if (pop) begin
            n_q_valid[0] = r_q_valid[1];
            n_q[0]       = r_q[1];
            n_q_valid[1] = 1'b0;
            n_q[1]       = r_q[1];
        end else begin
            n_q_valid[0] = r_q_valid[0];
            n_q[0]       = r_q[0];
            n_q_valid[1] = r_q_valid[1];
            n_q[1]       = r_q[1];
        end
        if (s1_go) begin
            if (r_s1_sel.res_main && r_s1_sel.res_end) begin
                n_q_valid[0] = 1'b1;
                n_q[0]       = res_main;
                n_q_valid[1] = 1'b1;
                n_q[1]       = res_end;
            end else if (r_s1_sel.res_main || r_s1_sel.res_end) begin
                if (n_q_valid[0]) begin
                    n_q_valid[1] = 1'b1;
                    n_q[1]       = r_s1_sel.res_main ? res_main : res_end;
                end else begin
                    n_q_valid[0] = 1'b1;
                    n_q[0]       = r_s1_sel.res_main ? res_main : res_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_held       <= '0;
            r_q_valid[0] <= 1'b0;
            r_q_valid[1] <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            // The pixel above this one becomes the next pixel's upper-left.
            if (s1_go) begin
                r_held <= above;
            end
            r_q_valid[0] <= n_q_valid[0];
            r_q_valid[1] <= n_q_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= s_tdata[rdes_pkg::PIX_W-1:0];
            r_s1_sel <= sel0;
        end
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign m_tvalid = r_q_valid[0];
    assign m_tdata  = r_q[0].edge_res;
    assign m_tlast  = r_q[0].end_of_row;
    assign m_tuser  = r_q[0].last;

    // ---------------- Assertions ----------------
    a_queue_no_hole : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid[1] |-> r_q_valid[0])
        else $error("output queue tail valid while head empty");

    a_pair_into_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_sel.res_main && r_s1_sel.res_end)
            |-> (!r_q_valid[0] || (pop && !r_q_valid[1])))
        else $error("two results pushed into an occupied queue");

    a_row_end_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("end-of-row result not marked as last of its pixel");

    a_accept_loads_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel did not reach the compute stage");

    a_stall_holds_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !push_ok) |=> (r_s1_valid && $stable(r_s1_pix)))
        else $error("stalled compute stage lost its pixel");

endmodule

[design/rdes_line_store.sv]
// Single-port line store for the Roberts diagonal edge stream block.
// Read-first synchronous RAM with a registered read port; uses rdes_pkg.
module rdes_line_store #(
    parameter int DEPTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [$clog2(DEPTH)-1:0]        i_addr,
    input  logic [rdes_pkg::PIX_W-1:0]      i_wdata,
    output logic [rdes_pkg::PIX_W-1:0]      o_rdata
);

    logic [rdes_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [rdes_pkg::PIX_W-1:0] r_rdata;

    // The read returns the entry's old contents when the same cycle writes it.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule
